// File: design/imu_fifo_complementary_filter_unit_macros.svh
// Assertion macros shared by the filter unit.
`ifndef IMU_FIFO_COMPLEMENTARY_FILTER_UNIT_MACROS_SVH
`define IMU_FIFO_COMPLEMENTARY_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IFCF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IFCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/imu_cf_pkg.sv
package imu_cf_pkg;

	localparam int GYRO_SHARE_SHIFT = 2;
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [31:0] HALF_TURN_Q16 = 32'sd11796480;
	localparam int CORDIC_STEPS = 20;

	typedef enum logic [1:0] {
		REG_GYRO_SCALE  = 2'd0,
		REG_ACCEL_SCALE = 2'd1,
		REG_GYRO_WEIGHT = 2'd2,
		REG_CAL_FIRST   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic signed [31:0] gz;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic               cal;
	} blk_t;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > 52'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -52'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [21:0] atan_tab(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0: r = 22'd2949120;
			5'd1: r = 22'd1740967;
			5'd2: r = 22'd919879;
			5'd3: r = 22'd466945;
			5'd4: r = 22'd234379;
			5'd5: r = 22'd117304;
			5'd6: r = 22'd58666;
			5'd7: r = 22'd29335;
			5'd8: r = 22'd14668;
			5'd9: r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

// File: design/imu_cf_front.sv
module imu_cf_front import imu_cf_pkg::*; #(
	parameter int BLOCK_WORDS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample,
	input  logic               block_start,
	input  logic [3:0]         start_slot,
	input  logic [23:0]        gyro_scale,
	input  logic [23:0]        accel_scale,
	input  logic               cal_wr,
	input  logic               cal_val,
	input  logic               q_full,
	output logic               q_push,
	output blk_t               q_data
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_ACC  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t state_q;
	logic [3:0] wc_q, pslot_q;
	logic cal_q;
	logic signed [31:0] gsum_q [3];
	logic signed [31:0] alat_q [3];
	logic signed [31:0] goff_q [3];
	logic signed [31:0] aoff_q [3];

	logic signed [15:0] sample_s1;
	logic is_acc_s1, done_s1;
	logic [1:0] axis_s1;
	logic signed [40:0] prod_s2;

	logic accept, open_blk;
	logic [3:0] slot, wcn;
	logic signed [24:0] scaled;
	logic signed [31:0] goff_sel, share;
	logic [1:0] axis;

	assign in_stall = (state_q != F_IDLE);
	assign accept = in_valid && (state_q == F_IDLE);
	assign open_blk = block_start || (wc_q == 4'd0);

	always_comb begin
		if (block_start) begin
			slot = (start_slot == 4'd15) ? 4'd0 : start_slot;
		end else begin
			slot = pslot_q;
		end
		wcn = (open_blk ? 4'd0 : wc_q) + 4'd1;
		unique case (slot)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12: axis = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13: axis = 2'd1;
			default: axis = 2'd2;
		endcase
	end

	assign scaled = 25'((prod_s2 + 41'sd32768) >>> 16);
	assign goff_sel = goff_q[axis_s1];
	// Offset share truncates toward zero, so negative values get a bias first.
	assign share = (goff_sel + (goff_sel[31] ? 32'sd3 : 32'sd0)) >>> GYRO_SHARE_SHIFT;

	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data = '{gx: gsum_q[0], gy: gsum_q[1], gz: gsum_q[2],
		ax: alat_q[0], ay: alat_q[1], az: alat_q[2], cal: cal_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			is_acc_s1 <= (slot >= 4'd3) && (slot <= 4'd5);
			axis_s1 <= axis;
			done_s1 <= (wcn == 4'(BLOCK_WORDS));
		end
		if (state_q == F_MUL) begin
			prod_s2 <= 41'(sample_s1) *
				$signed({1'b0, (is_acc_s1 ? accel_scale : gyro_scale)});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wc_q <= '0;
			pslot_q <= '0;
			cal_q <= 1'b1;
			for (int k = 0; k < 3; k++) begin
				gsum_q[k] <= '0;
				alat_q[k] <= '0;
				goff_q[k] <= '0;
				aoff_q[k] <= '0;
			end
		end else begin
			if (cal_wr) begin
				cal_q <= cal_val;
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (open_blk) begin
							for (int k = 0; k < 3; k++) begin
								gsum_q[k] <= '0;
								alat_q[k] <= '0;
							end
						end
						pslot_q <= (slot == 4'd14) ? 4'd0 : slot + 4'd1;
						wc_q <= (wcn == 4'(BLOCK_WORDS)) ? 4'd0 : wcn;
						state_q <= F_MUL;
					end
				end
				F_MUL: state_q <= F_ACC;
				F_ACC: begin
					if (is_acc_s1) begin
						alat_q[axis_s1] <= sat32(52'(scaled) - 52'(aoff_q[axis_s1]));
					end else begin
						gsum_q[axis_s1] <= sat32(52'(gsum_q[axis_s1]) + 52'(scaled)
							- 52'(share));
					end
					state_q <= done_s1 ? F_PUSH : F_IDLE;
				end
				F_PUSH: begin
					if (!q_full) begin
						if (cal_q) begin
							for (int k = 0; k < 2; k++) begin
								goff_q[k] <= sat32(52'(goff_q[k]) + 52'(gsum_q[k]));
								aoff_q[k] <= sat32(52'(aoff_q[k]) + 52'(alat_q[k]));
							end
							goff_q[2] <= sat32(52'(goff_q[2]) + 52'(gsum_q[2]));
							aoff_q[2] <= sat32(52'(sat32(52'(aoff_q[2]) + 52'(alat_q[2])))
								- 52'(ONE_Q16));
							cal_q <= 1'b0;
						end
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: design/imu_cf_queue.sv
module imu_cf_queue import imu_cf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  blk_t wdata,
	input  logic pop,
	output blk_t rdata,
	output logic full,
	output logic empty
);

	blk_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
		end
	end

endmodule

// File: design/imu_cf_back.sv
module imu_cf_back import imu_cf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  blk_t               q_data,
	output logic               q_pop,
	input  logic [16:0]        gyro_weight,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               out_load,
	output logic signed [31:0] tilt_x,
	output logic signed [31:0] tilt_y,
	output logic signed [31:0] heading_z,
	output logic               was_calibration
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_CORD = 4'b0010,
		B_MUL  = 4'b0100,
		B_FIN  = 4'b1000
	} bstate_t;

	bstate_t state_q;
	logic signed [31:0] ang_q [3];
	logic out_valid_q;
	blk_t blk_q;
	logic signed [33:0] cx_q [2];
	logic signed [33:0] cy_q [2];
	logic signed [31:0] cz_q [2];
	logic [4:0] it_q;
	logic signed [51:0] px1_q, px2_q, py1_q, py2_q;

	logic out_free;
	logic signed [33:0] ix [2];
	logic signed [33:0] iy [2];
	logic signed [31:0] iz [2];
	logic signed [17:0] w, wa;
	logic signed [32:0] gx, gy;

	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign q_pop = (state_q == B_IDLE) && !q_empty && out_free;
	assign out_load = (q_pop && q_data.cal) || ((state_q == B_FIN) && out_free);

	assign w = (gyro_weight > 17'd65536) ? 18'sd65536 : $signed({1'b0, gyro_weight});
	assign wa = 18'sd65536 - w;
	assign gx = 33'(ang_q[0]) + 33'(blk_q.gx);
	assign gy = 33'(ang_q[1]) - 33'(blk_q.gy);

	// Lane 0 resolves atan2(ay, az), lane 1 resolves atan2(ax, az).
	always_comb begin
		iy[0] = 34'(q_data.ay);
		iy[1] = 34'(q_data.ax);
		for (int l = 0; l < 2; l++) begin
			ix[l] = 34'(q_data.az);
			iz[l] = '0;
			if (q_data.az < 0) begin
				iz[l] = (iy[l] >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
				ix[l] = -ix[l];
				iy[l] = -iy[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			blk_q <= q_data;
			for (int l = 0; l < 2; l++) begin
				cx_q[l] <= ix[l];
				cy_q[l] <= iy[l];
				cz_q[l] <= iz[l];
			end
		end else if (state_q == B_CORD) begin
			for (int l = 0; l < 2; l++) begin
				if (cy_q[l] >= 0) begin
					cx_q[l] <= cx_q[l] + (cy_q[l] >>> it_q);
					cy_q[l] <= cy_q[l] - (cx_q[l] >>> it_q);
					cz_q[l] <= cz_q[l] + 32'(atan_tab(it_q));
				end else begin
					cx_q[l] <= cx_q[l] - (cy_q[l] >>> it_q);
					cy_q[l] <= cy_q[l] + (cx_q[l] >>> it_q);
					cz_q[l] <= cz_q[l] - 32'(atan_tab(it_q));
				end
			end
		end
		if (state_q == B_MUL) begin
			// A zero vector gives an angle of zero.
			px1_q <= 52'(w) * 52'(gx);
			px2_q <= 52'(wa) * ((blk_q.ay == 0 && blk_q.az == 0) ? 52'sd0 : 52'(cz_q[0]));
			py1_q <= 52'(w) * 52'(gy);
			py2_q <= 52'(wa) * ((blk_q.ax == 0 && blk_q.az == 0) ? 52'sd0 : 52'(cz_q[1]));
		end
		if (out_load) begin
			if (state_q == B_FIN) begin
				tilt_x <= sat32((px1_q + px2_q + 52'sd32768) >>> 16);
				tilt_y <= sat32((py1_q + py2_q + 52'sd32768) >>> 16);
				heading_z <= sat32(52'(ang_q[2]) + 52'(blk_q.gz));
				was_calibration <= 1'b0;
			end else begin
				tilt_x <= ang_q[0];
				tilt_y <= ang_q[1];
				heading_z <= ang_q[2];
				was_calibration <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			it_q <= '0;
			for (int k = 0; k < 3; k++) begin
				ang_q[k] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					it_q <= '0;
					if (q_pop && !q_data.cal) begin
						state_q <= B_CORD;
					end
				end
				B_CORD: begin
					it_q <= it_q + 5'd1;
					if (it_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= B_MUL;
					end
				end
				B_MUL: state_q <= B_FIN;
				B_FIN: begin
					if (out_free) begin
						ang_q[0] <= sat32((px1_q + px2_q + 52'sd32768) >>> 16);
						ang_q[1] <= sat32((py1_q + py2_q + 52'sd32768) >>> 16);
						ang_q[2] <= sat32(52'(ang_q[2]) + 52'(blk_q.gz));
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// File: design/imu_fifo_complementary_filter_unit.sv
// Each accepted word takes the front end through three steps (accept, scale multiply, accumulate);
// the word that closes a block adds a push step to hand the block summary to the queue.
// The back end loads a calibration result in the cycle it pops the block and takes a
// filter block through pop, 20 CORDIC iterations, one blend multiply and a finish step.
// The front end takes no new word until done with the last; its scale multiplier is 16x24.
// Reset clears all sums, offsets and angles, loads register defaults, and arms calibration.
module imu_fifo_complementary_filter_unit import imu_cf_pkg::*; #(
	parameter int BLOCK_WORDS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample,
	input  logic               block_start,
	input  logic [3:0]         start_slot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] tilt_x,
	output logic signed [31:0] tilt_y,
	output logic signed [31:0] heading_z,
	output logic               was_calibration,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

`include "imu_fifo_complementary_filter_unit_macros.svh"

	// Configuration registers. Writes are always taken, as cfg_ready is held high.
	logic [23:0] gyro_scale_q, accel_scale_q;
	logic [16:0] gyro_weight_q;
	logic cfg_wr, cal_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign cal_wr = cfg_wr && (reg_idx_t'(cfg_index) == REG_CAL_FIRST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_scale_q <= 24'd157544;
			accel_scale_q <= 24'd262152;
			gyro_weight_q <= 17'd63570;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GYRO_SCALE: gyro_scale_q <= cfg_data;
				REG_ACCEL_SCALE: accel_scale_q <= cfg_data;
				REG_GYRO_WEIGHT: gyro_weight_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// The front end sorts each word by pattern slot and accumulates it; at the end of a
	// block it hands the block summary to the queue and, in calibration, stores offsets.
	logic q_push, q_pop, q_full, q_empty, out_load;
	blk_t q_wdata, q_rdata;

	imu_cf_front #(.BLOCK_WORDS(BLOCK_WORDS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .block_start(block_start), .start_slot(start_slot),
		.gyro_scale(gyro_scale_q), .accel_scale(accel_scale_q),
		.cal_wr(cal_wr), .cal_val(cfg_data[0]),
		.q_full(q_full), .q_push(q_push), .q_data(q_wdata)
	);

	// A two-entry queue lets the front end keep taking words while atan2 runs.
	imu_cf_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata(q_wdata),
		.pop(q_pop), .rdata(q_rdata),
		.full(q_full), .empty(q_empty)
	);

	// The back end runs the CORDIC, blends and holds the angles and the output register.
	imu_cf_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
		.gyro_weight(gyro_weight_q),
		.out_stall(out_stall), .out_valid(out_valid), .out_load(out_load),
		.tilt_x(tilt_x), .tilt_y(tilt_y), .heading_z(heading_z),
		.was_calibration(was_calibration)
	);

	`IFCF_ASSERT_NOW(a_push_not_full, q_push, !q_full, "block pushed into a full queue")
	`IFCF_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "block popped from an empty queue")
	`IFCF_ASSERT_NOW(a_load_free, out_load, !out_valid || !out_stall, "result overwrote a word")
	`IFCF_ASSERT_NEXT(a_load_valid, out_load, out_valid, "loaded result not presented")

endmodule
